// ===== rtl/pidl_pkg.sv =====
package pidl_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = 5;
	localparam int ECNT_W = 5;
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [2:0] CMD_APPEND     = 3'd0;
	localparam logic [2:0] CMD_INS_FRONT  = 3'd1;
	localparam logic [2:0] CMD_INS_POS    = 3'd2;
	localparam logic [2:0] CMD_DEL_FIRST  = 3'd3;
	localparam logic [2:0] CMD_DEL_LAST   = 3'd4;
	localparam logic [2:0] CMD_DEL_POS    = 3'd5;
	localparam logic [2:0] CMD_DUMP       = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0]        command;
		logic signed [31:0] value;
		logic [POS_W-1:0]  position;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item_value;
		logic [ECNT_W-1:0]  entry_count;
		logic               last;
	} rsp_item_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2,
		OP_ROT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] idx;
		logic [CNT_W-1:0] cnt;
	} cell_ctl_t;

endpackage

// ===== rtl/pidl_cell.sv =====
module pidl_cell (
	input  logic                clk,
	input  pidl_pkg::cell_ctl_t ctl,
	input  logic [pidl_pkg::IDX_W-1:0] my_idx,
	input  logic signed [31:0]  left_val,
	input  logic signed [31:0]  right_val,
	input  logic signed [31:0]  ins_val,
	input  logic signed [31:0]  front_val,
	output logic signed [31:0]  val_q
);
	import pidl_pkg::*;

	logic [CNT_W-1:0]   me;
	logic [CNT_W-1:0]   me_p1;
	logic signed [31:0] val_d;

	assign me    = CNT_W'(my_idx);
	assign me_p1 = me + CNT_W'(1);

	always_comb begin
		val_d = val_q;
		unique case (ctl.op)
			OP_INS: begin
				if (me == ctl.idx) begin
					val_d = ins_val;
				end else if (me > ctl.idx && me <= ctl.cnt) begin
					val_d = left_val;
				end
			end
			OP_DEL: begin
				if (me >= ctl.idx && me_p1 < ctl.cnt) begin
					val_d = right_val;
				end
			end
			OP_ROT: begin
				// front entry wraps to the back of the occupied range
				if (me_p1 < ctl.cnt) begin
					val_d = right_val;
				end else if (me_p1 == ctl.cnt) begin
					val_d = front_val;
				end
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

// ===== rtl/positional_insert_delete_list.sv =====
// channel | direction | payload    | handshake
// req     | into block| req_item_t | req_valid / req_stall
// rsp     | out       | rsp_item_t | rsp_valid / rsp_stall
// an edit item takes effect on the edge that accepts it: all cells shift together and the
// status item is registered on the same edge. a dump takes the item, then sends one entry
// per cycle while the output is not stalled, rotating the cell chain through its front
// cell; no new item is taken meanwhile.
// reset clears the count and control state; cell contents are not reset.
// rsp_stall holds the output register and, through it, stalls req.
module positional_insert_delete_list (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pidl_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pidl_pkg::rsp_item_t rsp
);
	import pidl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rem_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic signed [31:0] vals [CAPACITY];
	cell_ctl_t          ctl;
	logic               out_free;
	logic               accept;
	logic               load;
	rsp_item_t          rsp_d;
	logic [CNT_W-1:0]   count_d;
	logic [CNT_W-1:0]   rem_d;
	state_t             state_d;
	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   cnt_ext;
	logic [CMP_W-1:0]   cnt_d_ext;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !(state_q == S_IDLE && out_free);
	assign accept    = req_valid && !req_stall;
	assign pos_ext   = CMP_W'(req.position);
	assign cnt_ext   = CMP_W'(count_q);
	assign cnt_d_ext = CMP_W'(count_d);

	always_comb begin
		ctl.op   = OP_HOLD;
		ctl.idx  = '0;
		ctl.cnt  = count_q;
		load     = 1'b0;
		count_d  = count_q;
		rem_d    = rem_q;
		state_d  = state_q;
		rsp_d.status      = ST_OK;
		rsp_d.item_value  = '0;
		rsp_d.entry_count = '0;
		rsp_d.last        = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					priority if (req.command == CMD_APPEND || req.command == CMD_INS_FRONT ||
						req.command == CMD_INS_POS) begin
						if (count_q == CNT_W'(CAPACITY)) begin
							rsp_d.status = ST_FULL;
						end else if (req.command == CMD_APPEND) begin
							ctl.op = OP_INS;
							ctl.idx = count_q;
						end else if (req.command == CMD_INS_FRONT) begin
							ctl.op = OP_INS;
						end else if (pos_ext < CMP_W'(1) || pos_ext > cnt_ext + CMP_W'(1)) begin
							rsp_d.status = ST_RANGE;
						end else begin
							ctl.op = OP_INS;
							ctl.idx = CNT_W'(pos_ext - CMP_W'(1));
						end
						if (ctl.op == OP_INS) begin
							count_d = count_q + CNT_W'(1);
						end
					end else if (req.command == CMD_DEL_FIRST || req.command == CMD_DEL_LAST ||
						req.command == CMD_DEL_POS) begin
						if (count_q == '0) begin
							rsp_d.status = ST_EMPTY;
						end else if (req.command == CMD_DEL_FIRST) begin
							ctl.op = OP_DEL;
						end else if (req.command == CMD_DEL_LAST) begin
							ctl.op = OP_DEL;
							ctl.idx = count_q - CNT_W'(1);
						end else if (pos_ext < CMP_W'(1) || pos_ext > cnt_ext) begin
							rsp_d.status = ST_RANGE;
						end else begin
							ctl.op = OP_DEL;
							ctl.idx = CNT_W'(pos_ext - CMP_W'(1));
						end
						if (ctl.op == OP_DEL) begin
							count_d = count_q - CNT_W'(1);
						end
					end else if (req.command == CMD_DUMP) begin
						if (count_q == '0) begin
							rsp_d.status = ST_EMPTY;
						end else begin
							// first entry goes out later from the dump state
							load    = 1'b0;
							rem_d   = count_q;
							state_d = S_DUMP;
						end
					end else begin
						rsp_d.status = ST_OK;
					end
					rsp_d.entry_count = cnt_d_ext[ECNT_W-1:0];
				end
			end
			S_DUMP: begin
				if (out_free) begin
					load   = 1'b1;
					ctl.op = OP_ROT;
					rsp_d.item_value  = vals[0];
					rsp_d.entry_count = cnt_ext[ECNT_W-1:0];
					rsp_d.last        = (rem_q == CNT_W'(1));
					rem_d = rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] lv;
		logic signed [31:0] rv;
		if (i == 0) begin : g_first
			assign lv = '0;
		end else begin : g_mid_l
			assign lv = vals[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv = '0;
		end else begin : g_mid_r
			assign rv = vals[i+1];
		end
		pidl_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.my_idx    (IDX_W'(i)),
			.left_val  (lv),
			.right_val (rv),
			.ins_val   (req.value),
			.front_val (vals[0]),
			.val_q     (vals[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (out_free) begin
				rsp_valid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== dv/positional_insert_delete_list_test.sv =====
module positional_insert_delete_list_test;
	import pidl_pkg::*;

	// command code with no operation behind it
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int QUIET_LIMIT = 500;
	localparam int TAIL_CYCLES = 24;
	localparam int RANDOM_ITEMS = 145;

	class list_shadow;
		logic signed [31:0] cells[$];
		rsp_item_t replies_due[$];
		int mismatches = 0;

		function void add_reply(logic [1:0] st, logic [31:0] v, logic fin);
			rsp_item_t r;
			r.status = st;
			r.item_value = v;
			r.entry_count = ECNT_W'(cells.size());
			r.last = fin;
			replies_due.push_back(r);
		endfunction

		function void apply_command(req_item_t it);
			logic [1:0] st;
			int fill;
			st = ST_OK;
			fill = cells.size();
			case (it.command)
				CMD_APPEND, CMD_INS_FRONT, CMD_INS_POS: begin
					if (fill >= CAPACITY)
						st = ST_FULL;
					else if (it.command == CMD_APPEND)
						cells.push_back(it.value);
					else if (it.command == CMD_INS_FRONT)
						cells.push_front(it.value);
					else if (it.position < 1 || it.position > fill + 1)
						st = ST_RANGE;
					else
						cells.insert(it.position - 1, it.value);
				end
				CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS: begin
					if (fill == 0)
						st = ST_EMPTY;
					else if (it.command == CMD_DEL_FIRST)
						cells.delete(0);
					else if (it.command == CMD_DEL_LAST)
						cells.delete(fill - 1);
					else if (it.position < 1 || it.position > fill)
						st = ST_RANGE;
					else
						cells.delete(it.position - 1);
				end
				CMD_DUMP: begin
					if (fill == 0)
						add_reply(ST_EMPTY, '0, 1'b1);
					for (int i = 0; i < fill; i++)
						add_reply(ST_OK, cells[i], i == fill - 1);
					return;
				end
				default: ;
			endcase
			add_reply(st, '0, 1'b1);
		endfunction

		function void check_reply(rsp_item_t got);
			rsp_item_t want;
			if (replies_due.size() == 0) begin
				$error("unexpected reply item: %p", got);
				mismatches++;
				return;
			end
			want = replies_due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.item_value !== want.item_value) begin
				$error("item_value: expected %0d, got %0d", want.item_value, got.item_value);
				mismatches++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count,
					got.entry_count);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_item_t rsp;

	bit idling_on = 1'b1;
	list_shadow shadow = new();

	always #5 clk = ~clk;

	positional_insert_delete_list u_top (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			shadow.apply_command(req);
		if (arst_n && rsp_valid && !rsp_stall)
			shadow.check_reply(rsp);
	end

	// receiver backpressure in bursts
	always begin
		@(negedge clk);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			repeat ($urandom_range(1, 16)) @(negedge clk);
			rsp_stall <= 1'b0;
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// called and returns at a falling edge; returns once the item is taken
	task automatic send_command(input logic [2:0] cmd, input logic [31:0] v,
			input logic [POS_W-1:0] pos);
		req_item_t it;
		it.command = cmd;
		it.value = v;
		it.position = pos;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	initial begin
		bit growing;
		int fill;
		int pick;
		logic [2:0] cmd;
		logic [31:0] v;
		logic [POS_W-1:0] pos;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list corners
		send_command(CMD_DUMP, 32'h0, 5'd0);
		send_command(CMD_DEL_FIRST, 32'h1, 5'd1);
		send_command(CMD_DEL_LAST, 32'h2, 5'd1);
		send_command(CMD_DEL_POS, 32'h3, 5'd1);
		send_command(CMD_INS_POS, 32'h4, 5'd0);
		send_command(CMD_INS_POS, 32'h5, 5'd2);
		// insert at count+1 on an empty list, then each single-entry delete
		send_command(CMD_INS_POS, 32'h5, 5'd1);
		send_command(CMD_DEL_FIRST, 32'h0, 5'd31);
		send_command(CMD_APPEND, 32'h7, 5'd0);
		send_command(CMD_DEL_LAST, 32'h0, 5'd0);
		send_command(CMD_INS_FRONT, 32'h9, 5'd0);
		send_command(CMD_DEL_POS, 32'h0, 5'd1);
		send_command(CMD_UNUSED, 32'hffff_ffff, 5'd31);
		// value extremes and position edges
		send_command(CMD_APPEND, 32'h7fff_ffff, 5'd0);
		send_command(CMD_INS_FRONT, 32'h8000_0000, 5'd0);
		send_command(CMD_INS_POS, 32'h0, 5'd3);
		send_command(CMD_INS_POS, 32'hffff_ffff, 5'd2);
		send_command(CMD_DEL_POS, 32'h0, 5'd0);
		send_command(CMD_DEL_POS, 32'h0, 5'd5);
		send_command(CMD_INS_POS, 32'h1234_5678, 5'd6);
		send_command(CMD_INS_POS, 32'h1234_5678, 5'd31);
		send_command(CMD_DUMP, 32'hffff_ffff, 5'd31);
		send_command(CMD_UNUSED, 32'h0, 5'd0);
		send_command(CMD_DEL_POS, 32'h0, 5'd4);
		send_command(CMD_DUMP, 32'h0, 5'd0);

		growing = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 20 == 0)
				idling_on = (n < RANDOM_ITEMS - 30) && ($urandom_range(0, 3) != 0);
			fill = shadow.cells.size();
			// sweep between empty and full, poking at each end a little
			if (fill == CAPACITY || fill == 0) begin
				if ($urandom_range(0, 2) == 0)
					growing = (fill == 0);
			end else if ($urandom_range(0, 19) == 0) begin
				growing = !growing;
			end
			v = $urandom;
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'h0;
					default: v = 32'hffff_ffff;
				endcase
			end
			pos = POS_W'($urandom_range(0, 31));
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				cmd = 3'($urandom_range(0, 7));
			end else if (pick <= 2) begin
				cmd = CMD_DUMP;
			end else if (growing) begin
				case ($urandom_range(0, 2))
					0: cmd = CMD_APPEND;
					1: cmd = CMD_INS_FRONT;
					default: cmd = CMD_INS_POS;
				endcase
				if (cmd == CMD_INS_POS)
					pos = POS_W'($urandom_range(1, fill + 1));
			end else begin
				case ($urandom_range(0, 2))
					0: cmd = CMD_DEL_FIRST;
					1: cmd = CMD_DEL_LAST;
					default: cmd = CMD_DEL_POS;
				endcase
				if (cmd == CMD_DEL_POS)
					pos = POS_W'($urandom_range(1, (fill == 0) ? 1 : fill));
			end
			send_command(cmd, v, pos);
		end
		req_valid <= 1'b0;

		while (shadow.replies_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/positional_insert_delete_list.sv
dv/positional_insert_delete_list_test.sv
